FILE: hw/rtl/mcmm_pkg.sv
// ----------------------------------------------------------------------------
// mcmm_pkg
// Shared widths, bus decode codes and register indexes of the multicart
// MMC3-style bank mapper.
// ----------------------------------------------------------------------------
package mcmm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int CHR_W      = 11;
    localparam int PRG_W      = 9;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int N_CHR      = 8;
    localparam int N_PRG      = 4;
    localparam int N_BANK     = N_CHR + N_PRG;
    localparam int SLOT_W     = 4;
    // CHR operands reach 13 bits (a 12-bit page plus one)
    localparam int DVD_W      = 13;
    localparam int BIT_CNT_W  = 4;

    // Address decode
    localparam logic [ADDR_W-1:0] ADDR_MASK  = 16'hE001;
    localparam logic [ADDR_W-1:0] ADDR_CTRL  = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK  = 16'h8001;
    localparam logic [ADDR_W-1:0] ADDR_LATCH = 16'hA001;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK = 16'h6000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_PAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_PAGES = 1'b1;

    localparam logic [CHR_W-1:0] CHR_PAGES_RST = 11'd8;
    localparam logic [PRG_W-1:0] PRG_PAGES_RST = 9'd2;

endpackage

FILE: hw/rtl/mcmm_in_if.sv
// ----------------------------------------------------------------------------
// mcmm_in_if
// CPU write channel: address and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface mcmm_in_if import mcmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output address, output data, input ready);
    modport sink   (input valid, input address, input data, output ready);
endinterface

FILE: hw/rtl/mcmm_out_if.sv
// ----------------------------------------------------------------------------
// mcmm_out_if
// Bank result channel: eight CHR pages and four PRG pages with valid/ready.
// ----------------------------------------------------------------------------
interface mcmm_out_if import mcmm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CHR_W-1:0] chr_bank_0;
    logic [CHR_W-1:0] chr_bank_1;
    logic [CHR_W-1:0] chr_bank_2;
    logic [CHR_W-1:0] chr_bank_3;
    logic [CHR_W-1:0] chr_bank_4;
    logic [CHR_W-1:0] chr_bank_5;
    logic [CHR_W-1:0] chr_bank_6;
    logic [CHR_W-1:0] chr_bank_7;
    logic [PRG_W-1:0] prg_bank_0;
    logic [PRG_W-1:0] prg_bank_1;
    logic [PRG_W-1:0] prg_bank_2;
    logic [PRG_W-1:0] prg_bank_3;

    modport source (
        output valid, input ready,
        output chr_bank_0, output chr_bank_1, output chr_bank_2, output chr_bank_3,
        output chr_bank_4, output chr_bank_5, output chr_bank_6, output chr_bank_7,
        output prg_bank_0, output prg_bank_1, output prg_bank_2, output prg_bank_3
    );
    modport sink (
        input valid, output ready,
        input chr_bank_0, input chr_bank_1, input chr_bank_2, input chr_bank_3,
        input chr_bank_4, input chr_bank_5, input chr_bank_6, input chr_bank_7,
        input prg_bank_0, input prg_bank_1, input prg_bank_2, input prg_bank_3
    );
endinterface

FILE: hw/rtl/multicart_mmc3_bank_mapper.sv
// ----------------------------------------------------------------------------
// multicart_mmc3_bank_mapper
// Decodes CPU bus writes into MMC3-style bank, control and outer-block
// registers and emits the twelve mapped pages after each recomputation.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          payload
//   i_in      in   valid/ready        address[15:0], data[7:0]
//   o_out     out  valid/ready        chr_bank_0..7[10:0], prg_bank_0..3[8:0]
//   i_cfg_*   in   write enable only  index[0], data[10:0]
//
// A write that changes registers without a result leaves the block idle. After
// a write that triggers a recomputation no CPU transfer is taken until the
// result is in the output register: every page is reduced by one shared
// bit-serial remainder unit, one dividend bit a cycle, after a load step for
// each page's 13-bit dividend. Reset is synchronous, active low, clears the
// mapper registers and the sequencer, and sets the page counts to defaults. A
// finished result waits in the output register while the next CPU transfer is
// taken; a new result only stalls if the previous one has not been transferred yet.
// ----------------------------------------------------------------------------
module multicart_mmc3_bank_mapper import mcmm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mcmm_in_if.sink              i_in,
    mcmm_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    // Mapper registers
    logic [DATA_W-1:0] r_bank [N_CHR];
    logic [DATA_W-1:0] r_block [4];
    logic [DATA_W-1:0] r_ctrl;
    logic              r_armed;
    logic [1:0]        r_pos;
    logic [CHR_W-1:0]  r_chr_pages;
    logic [PRG_W-1:0]  r_prg_pages;

    // Sequencer and remainder unit
    logic [1:0]           r_state;
    logic [SLOT_W-1:0]    r_slot;
    logic [BIT_CNT_W-1:0] r_bit;
    logic [DVD_W-1:0]     r_dvd;
    logic [CHR_W-1:0]     r_rem;
    logic [CHR_W-1:0]     r_acc [N_BANK];

    // Output register
    logic             r_out_valid;
    logic [CHR_W-1:0] r_out_chr [N_CHR];
    logic [PRG_W-1:0] r_out_prg [N_PRG];

    logic [ADDR_W-1:0] w_addr;
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_result;

    assign w_addr     = i_in.address & ADDR_MASK;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // A result follows control and bank writes, and every fourth armed
    // block write.
    always_comb begin
        w_result = 1'b0;
        if (w_addr == ADDR_CTRL || w_addr == ADDR_BANK) begin
            w_result = 1'b1;
        end else if (w_addr == ADDR_BLOCK && r_armed && r_pos == 2'd3) begin
            w_result = 1'b1;
        end
    end

    // ---------------- operand for the current slot ----------------
    logic [11:0]      w_c [6];
    logic [7:0]       w_m;
    logic [7:0]       w_p0, w_p1, w_p2, w_p3;
    logic [PRG_W-1:0] w_pm1;
    logic [2:0]       w_eff;
    logic [DVD_W-1:0] w_chr_op;
    logic [7:0]       w_prg_op;
    logic [DVD_W-1:0] n_op;
    logic [CHR_W-1:0] w_mod;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_c[i] = ({4'd0, r_bank[i]} | {r_block[1], 4'd0}) & {r_block[2], 4'hF};
        end
        w_m   = {2'b00, r_block[3][5:0] ^ 6'h3F};
        w_p0  = (r_bank[6] & w_m) | r_block[1];
        w_p1  = (r_bank[7] & w_m) | r_block[1];
        w_p3  = w_m | r_block[1];
        w_pm1 = r_prg_pages - 9'd1;
        w_p2  = w_p3 & w_pm1[7:0];

        // CHR swap exchanges the two halves of the pattern table
        w_eff = r_slot[2:0] ^ {r_ctrl[7], 2'b00};
        unique case (w_eff)
            3'd0:    w_chr_op = {1'b0, w_c[0]};
            3'd1:    w_chr_op = {1'b0, w_c[0]} + 13'd1;
            3'd2:    w_chr_op = {1'b0, w_c[1]};
            3'd3:    w_chr_op = {1'b0, w_c[1]} + 13'd1;
            3'd4:    w_chr_op = {1'b0, w_c[2]};
            3'd5:    w_chr_op = {1'b0, w_c[3]};
            3'd6:    w_chr_op = {1'b0, w_c[4]};
            default: w_chr_op = {1'b0, w_c[5]};
        endcase

        // PRG swap exchanges the 0x8000 and 0xC000 slots
        unique case (r_slot[1:0])
            2'd0:    w_prg_op = r_ctrl[6] ? w_p2 : w_p0;
            2'd1:    w_prg_op = w_p1;
            2'd2:    w_prg_op = r_ctrl[6] ? w_p0 : w_p2;
            default: w_prg_op = w_p3;
        endcase

        if (r_slot < SLOT_W'(N_CHR)) begin
            n_op  = w_chr_op;
            w_mod = r_chr_pages;
        end else begin
            n_op  = {5'd0, w_prg_op};
            w_mod = {2'b00, r_prg_pages};
        end
    end

    // ---------------- restoring remainder step ----------------
    logic [CHR_W:0]   w_trial;
    logic [CHR_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        if (w_mod == '0) begin
            n_rem = '0;
        end else if (w_trial >= {1'b0, w_mod}) begin
            n_rem = CHR_W'(w_trial - {1'b0, w_mod});
        end else begin
            n_rem = w_trial[CHR_W-1:0];
        end
    end

    // ---------------- register decode ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_CHR; i++) begin
                r_bank[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_block[i] <= '0;
            end
            r_ctrl      <= '0;
            r_armed     <= 1'b0;
            r_pos       <= '0;
            r_chr_pages <= CHR_PAGES_RST;
            r_prg_pages <= PRG_PAGES_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CHR_PAGES: r_chr_pages <= i_cfg_data;
                    default:       r_prg_pages <= i_cfg_data[PRG_W-1:0];
                endcase
            end
            if (w_in_xfer) begin
                priority if (w_addr == ADDR_CTRL) begin
                    r_ctrl <= i_in.data;
                end else if (w_addr == ADDR_BANK) begin
                    r_bank[r_ctrl[2:0]] <= i_in.data;
                end else if (w_addr == ADDR_LATCH) begin
                    // arm restarts the block sequence, disarm keeps position
                    r_armed <= i_in.data[7];
                    if (i_in.data[7]) begin
                        r_pos <= '0;
                    end
                end else if (w_addr == ADDR_BLOCK && r_armed) begin
                    r_block[r_pos] <= i_in.data;
                    r_pos          <= r_pos + 2'd1;
                end
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, else drop the one just transferred
            if (r_state == S_HOLD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && w_result) begin
                        r_slot  <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_dvd   <= n_op;
                    r_rem   <= '0;
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_rem <= n_rem;
                    r_bit <= r_bit + BIT_CNT_W'(1);
                    if (r_bit == BIT_CNT_W'(DVD_W - 1)) begin
                        r_acc[r_slot] <= n_rem;
                        if (r_slot == SLOT_W'(N_BANK - 1)) begin
                            r_state <= S_HOLD;
                        end else begin
                            r_slot  <= r_slot + SLOT_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        for (int i = 0; i < N_CHR; i++) begin
                            r_out_chr[i] <= r_acc[i];
                        end
                        for (int i = 0; i < N_PRG; i++) begin
                            r_out_prg[i] <= r_acc[N_CHR + i][PRG_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.chr_bank_0 = r_out_chr[0];
    assign o_out.chr_bank_1 = r_out_chr[1];
    assign o_out.chr_bank_2 = r_out_chr[2];
    assign o_out.chr_bank_3 = r_out_chr[3];
    assign o_out.chr_bank_4 = r_out_chr[4];
    assign o_out.chr_bank_5 = r_out_chr[5];
    assign o_out.chr_bank_6 = r_out_chr[6];
    assign o_out.chr_bank_7 = r_out_chr[7];
    assign o_out.prg_bank_0 = r_out_prg[0];
    assign o_out.prg_bank_1 = r_out_prg[1];
    assign o_out.prg_bank_2 = r_out_prg[2];
    assign o_out.prg_bank_3 = r_out_prg[3];

endmodule

FILE: test/multicart_mmc3_bank_mapper_tb.sv
// ----------------------------------------------------------------------------
// multicart_mmc3_bank_mapper_tb
// Drives CPU bus writes into the bank mapper through bursty valid/ready
// traffic. A shadow copy of the mapper registers predicts every set of twelve
// mapped pages. Each result transfer is checked field by field against the
// oldest prediction while the result side stalls on its own pattern. Runs
// several page-count settings, the extremes and zero among them.
// ----------------------------------------------------------------------------
module multicart_mmc3_bank_mapper_tb import mcmm_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    // long enough to settle after one full recomputation
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BURST_MAX      = 12;
    localparam int GAP_MAX        = 20;
    localparam int STALL_MAX      = 40;
    localparam int DIRECT_RANDOM  = 150;
    localparam int PHASE_RANDOM   = 175;
    localparam int N_PHASES       = 6;

    // Control byte and latch fields
    localparam int              CHR_SWAP_BIT = 7;
    localparam int              PRG_SWAP_BIT = 6;
    localparam logic [7:0]      SEL_MASK     = 8'h07;
    localparam logic [7:0]      ARM_FLAG     = 8'h80;
    localparam logic [7:0]      OUTER_MASK   = 8'h3F;
    localparam int unsigned     LOW_NIBBLE   = 'h0F;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_cpu_write;

    typedef struct packed {
        logic [N_CHR-1:0][CHR_W-1:0] chr;
        logic [N_PRG-1:0][PRG_W-1:0] prg;
    } t_page_set;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    mcmm_in_if  in_if ();
    mcmm_out_if out_if ();

    multicart_mmc3_bank_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow mapper state and page prediction
    // ------------------------------------------------------------------------
    logic [7:0]       shadow_bank [8];
    logic [7:0]       shadow_block [4];
    logic [7:0]       shadow_ctrl;
    logic             shadow_armed;
    logic [1:0]       shadow_pos;
    logic [CHR_W-1:0] chr_pages;
    logic [PRG_W-1:0] prg_pages;

    t_cpu_write cpu_write_q [$];
    t_page_set  page_expect_q [$];

    int mismatches;
    int writes_done;
    int results_seen;
    int settings_done;

    // Build the twelve pages from the shadow registers.
    function automatic t_page_set compute_pages();
        t_page_set   pages;
        int unsigned c [6];
        int unsigned chr_seq [8];
        int unsigned p [4];
        int unsigned prg_seq [4];
        int unsigned b1, b2, m, cm, pm;
        b1 = shadow_block[1];
        b2 = shadow_block[2];
        m  = (shadow_block[3] & OUTER_MASK) ^ OUTER_MASK;
        cm = chr_pages;
        pm = prg_pages;
        // OR in the outer block, then mask with the outer block size
        for (int i = 0; i < 6; i++)
            c[i] = (shadow_bank[i] | (b1 << 4)) & ((b2 << 4) | LOW_NIBBLE);
        if (shadow_ctrl[CHR_SWAP_BIT]) begin
            chr_seq = '{c[2], c[3], c[4], c[5], c[0], c[0] + 1, c[1], c[1] + 1};
        end else begin
            chr_seq = '{c[0], c[0] + 1, c[1], c[1] + 1, c[2], c[3], c[4], c[5]};
        end
        p[0] = (shadow_bank[6] & m) | b1;
        p[1] = (shadow_bank[7] & m) | b1;
        p[3] = m | b1;
        p[2] = (pm == 0) ? 0 : (p[3] & (pm - 1));
        if (shadow_ctrl[PRG_SWAP_BIT]) begin
            prg_seq = '{p[2], p[1], p[0], p[3]};
        end else begin
            prg_seq = '{p[0], p[1], p[2], p[3]};
        end
        // a zero page count maps every page to zero
        for (int i = 0; i < N_CHR; i++)
            pages.chr[i] = (cm == 0) ? '0 : CHR_W'(chr_seq[i] % cm);
        for (int i = 0; i < N_PRG; i++)
            pages.prg[i] = (pm == 0) ? '0 : PRG_W'(prg_seq[i] % pm);
        return pages;
    endfunction

    // Decode one accepted CPU write and queue the pages it causes, if any.
    function automatic void apply_cpu_write(input logic [ADDR_W-1:0] address,
                                            input logic [DATA_W-1:0] data);
        logic [ADDR_W-1:0] code;
        code = address & ADDR_MASK;
        case (code)
            ADDR_CTRL: begin
                shadow_ctrl = data;
                page_expect_q.push_back(compute_pages());
            end
            ADDR_BANK: begin
                shadow_bank[3'(shadow_ctrl & SEL_MASK)] = data;
                page_expect_q.push_back(compute_pages());
            end
            ADDR_LATCH: begin
                if (data[7]) begin
                    shadow_armed = 1'b1;
                    shadow_pos   = 2'd0;
                end else begin
                    shadow_armed = 1'b0;
                end
            end
            ADDR_BLOCK: begin
                // disarmed block writes are dropped; armed ones stay armed
                if (shadow_armed) begin
                    shadow_block[shadow_pos] = data;
                    shadow_pos = shadow_pos + 2'd1;
                    if (shadow_pos == 2'd0)
                        page_expect_q.push_back(compute_pages());
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_write(input logic [ADDR_W-1:0] address,
                                       input logic [DATA_W-1:0] data);
        t_cpu_write w;
        w.address = address;
        w.data    = data;
        cpu_write_q.push_back(w);
    endfunction

    // Fill the address bits that the decode ignores with random values.
    function automatic logic [ADDR_W-1:0] make_addr(input logic [ADDR_W-1:0] code);
        return code | (ADDR_W'($urandom) & ~ADDR_MASK);
    endfunction

    // Random byte, biased toward the extremes now and then.
    function automatic logic [DATA_W-1:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return DATA_W'($urandom);
    endfunction

    // Push one short sequence of CPU writes and return how many were pushed.
    function automatic int push_random_sequence();
        int kind, n, count, bitpos;
        logic [ADDR_W-1:0] code;
        kind  = $urandom_range(0, 99);
        count = 0;
        if (kind < 35) begin
            // select a bank register, then load it up to three times
            push_write(make_addr(ADDR_CTRL), rand_byte());
            count = 1;
            n = $urandom_range(0, 3);
            repeat (n) begin
                push_write(make_addr(ADDR_BANK), rand_byte());
                count++;
            end
        end else if (kind < 60) begin
            // well-formed outer block load: arm, one to three groups of four
            push_write(make_addr(ADDR_LATCH), rand_byte() | ARM_FLAG);
            count = 1;
            n = 4 * $urandom_range(1, 3);
            repeat (n) begin
                push_write(make_addr(ADDR_BLOCK), rand_byte());
                count++;
            end
            if ($urandom_range(0, 1) == 0) begin
                push_write(make_addr(ADDR_LATCH), rand_byte() & ~ARM_FLAG);
                count++;
            end
        end else if (kind < 70) begin
            // broken load: partial group, disarm, then writes that are dropped
            push_write(make_addr(ADDR_LATCH), rand_byte() | ARM_FLAG);
            count = 1;
            n = $urandom_range(1, 3);
            repeat (n) begin
                push_write(make_addr(ADDR_BLOCK), rand_byte());
                count++;
            end
            push_write(make_addr(ADDR_LATCH), rand_byte() & ~ARM_FLAG);
            count++;
            n = $urandom_range(1, 3);
            repeat (n) begin
                push_write(make_addr(ADDR_BLOCK), rand_byte());
                count++;
            end
        end else if (kind < 78) begin
            push_write(make_addr(ADDR_LATCH), rand_byte());
            count = 1;
        end else if (kind < 86) begin
            // block writes on whatever latch state the history left
            n = $urandom_range(1, 5);
            repeat (n) begin
                push_write(make_addr(ADDR_BLOCK), rand_byte());
                count++;
            end
        end else if (kind < 94) begin
            push_write(ADDR_W'($urandom), DATA_W'($urandom));
            count = 1;
        end else begin
            // one decoded bit away from a real code
            case ($urandom_range(0, 3))
                0:       code = ADDR_CTRL;
                1:       code = ADDR_BANK;
                2:       code = ADDR_LATCH;
                default: code = ADDR_BLOCK;
            endcase
            n = $urandom_range(0, 3);
            bitpos = (n == 0) ? 0 : 12 + n;
            push_write(make_addr(code) ^ (ADDR_W'(1) << bitpos), rand_byte());
            count = 1;
        end
        return count;
    endfunction

    // Hold until every pending write is accepted and every result has come;
    // optionally let the block settle for a full recomputation after that.
    task automatic wait_quiet(input bit settle);
        do @(negedge i_clk);
        while (cpu_write_q.size() != 0 || in_if.valid || page_expect_q.size() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Feed random sequences in chunks; now and then pause for all results.
    task automatic run_random(input int target);
        int pushed, chunk_end;
        pushed = 0;
        while (pushed < target) begin
            chunk_end = pushed + $urandom_range(10, 60);
            while (pushed < chunk_end && pushed < target)
                pushed += push_random_sequence();
            do @(negedge i_clk);
            while (cpu_write_q.size() != 0);
            if ($urandom_range(0, 4) == 0)
                wait_quiet(1'b0);
        end
    endtask

    // Write both page counts; only called while the block is idle.
    task automatic write_page_counts(input logic [CHR_W-1:0] chr,
                                     input logic [PRG_W-1:0] prg);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CHR_PAGES;
        i_cfg_data  <= CFG_W'(chr);
        @(posedge i_clk);
        i_cfg_index <= CFG_PRG_PAGES;
        i_cfg_data  <= CFG_W'(prg);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chr_pages = chr;
        prg_pages = prg;
        settings_done++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of transfers from the pending queue, random gaps between
    // ------------------------------------------------------------------------
    t_cpu_write drv_item;
    int         burst_left;
    int         gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            // predict on the transfer that completes at this edge
            if (in_if.valid && in_if.ready) begin
                apply_cpu_write(in_if.address, in_if.data);
                writes_done++;
            end
            // advance only once the current item has gone
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (cpu_write_q.size() != 0) begin
                    drv_item = cpu_write_q.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.address <= drv_item.address;
                    in_if.data    <= drv_item.data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, BURST_MAX);
                        // about a quarter of bursts run straight into the next
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer, stall ready on its own pattern
    // ------------------------------------------------------------------------
    t_page_set mon_pages;
    t_page_set mon_expect;
    int        stall_left;
    int        mode_left;
    bit        stall_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
            mode_left  = 0;
            stall_mode = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                mon_pages.chr[0] = out_if.chr_bank_0;
                mon_pages.chr[1] = out_if.chr_bank_1;
                mon_pages.chr[2] = out_if.chr_bank_2;
                mon_pages.chr[3] = out_if.chr_bank_3;
                mon_pages.chr[4] = out_if.chr_bank_4;
                mon_pages.chr[5] = out_if.chr_bank_5;
                mon_pages.chr[6] = out_if.chr_bank_6;
                mon_pages.chr[7] = out_if.chr_bank_7;
                mon_pages.prg[0] = out_if.prg_bank_0;
                mon_pages.prg[1] = out_if.prg_bank_1;
                mon_pages.prg[2] = out_if.prg_bank_2;
                mon_pages.prg[3] = out_if.prg_bank_3;
                if (page_expect_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, chr %h prg %h",
                             $time, mon_pages.chr, mon_pages.prg);
                    mismatches++;
                end else begin
                    mon_expect = page_expect_q.pop_front();
                    for (int i = 0; i < N_CHR; i++) begin
                        if (mon_pages.chr[i] !== mon_expect.chr[i]) begin
                            $display("%0t: chr_bank_%0d expected %0d actual %0d",
                                     $time, i, mon_expect.chr[i], mon_pages.chr[i]);
                            mismatches++;
                        end
                    end
                    for (int i = 0; i < N_PRG; i++) begin
                        if (mon_pages.prg[i] !== mon_expect.prg[i]) begin
                            $display("%0t: prg_bank_%0d expected %0d actual %0d",
                                     $time, i, mon_expect.prg[i], mon_pages.prg[i]);
                            mismatches++;
                        end
                    end
                end
            end
            // alternate long stretches of steady ready with stretches of stalls
            if (mode_left == 0) begin
                stall_mode = ($urandom_range(0, 2) != 0);
                mode_left  = $urandom_range(200, 1500);
            end else begin
                mode_left--;
            end
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (stall_mode && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, STALL_MAX);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if work is pending but nothing transfers
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cpu_write_q.size() == 0 && !in_if.valid && page_expect_q.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, page_expect_q.size());
                $display("multicart_mmc3_bank_mapper_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // known values on every input before the first edge
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_CHR_PAGES;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.address = '0;
        in_if.data    = '0;
        out_if.ready  = 1'b0;
        mismatches    = 0;
        writes_done   = 0;
        results_seen  = 0;
        settings_done = 0;

        // shadow state after reset
        for (int i = 0; i < 8; i++) shadow_bank[i] = 8'h00;
        for (int i = 0; i < 4; i++) shadow_block[i] = 8'h00;
        shadow_ctrl  = 8'h00;
        shadow_armed = 1'b0;
        shadow_pos   = 2'd0;
        chr_pages    = CHR_PAGES_RST;
        prg_pages    = PRG_PAGES_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset page counts.
        // Pages straight out of reset.
        push_write(ADDR_CTRL, 8'h00);
        push_write(ADDR_BANK | ~ADDR_MASK, 8'hFF);
        // both swap modes, last bank register
        push_write(ADDR_CTRL | ~ADDR_MASK, 8'hC7);
        push_write(ADDR_BANK, 8'h80);
        push_write(ADDR_CTRL, 8'h86);
        push_write(ADDR_BANK, 8'h7F);
        push_write(ADDR_CTRL, 8'h45);
        push_write(ADDR_BANK | ~ADDR_MASK, 8'h01);
        // block write while disarmed is dropped
        push_write(ADDR_LATCH, 8'h00);
        push_write(ADDR_BLOCK, 8'h55);
        // arm and fill: full outer OR, smallest size, empty mask
        push_write(ADDR_LATCH | ~ADDR_MASK, 8'h80);
        push_write(ADDR_BLOCK, 8'hFF);
        push_write(ADDR_BLOCK, 8'hFF);
        push_write(ADDR_BLOCK, 8'h00);
        push_write(ADDR_BLOCK | ~ADDR_MASK, 8'h3F);
        // latch stays armed: a second group of four recomputes again
        push_write(ADDR_BLOCK, 8'h00);
        push_write(ADDR_BLOCK, 8'hF0);
        push_write(ADDR_BLOCK, 8'h0F);
        push_write(ADDR_BLOCK, 8'hC0);
        // two addresses that decode to nothing, then a control and a latch write
        push_write(16'hFFFF, 8'hFF);
        push_write(16'h0000, 8'h00);
        push_write(ADDR_CTRL, 8'hFF);
        push_write(ADDR_LATCH, 8'h7F);

        run_random(DIRECT_RANDOM);
        wait_quiet(1'b1);

        // Sweep page-count settings: both extremes, zero, then random ones.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       write_page_counts(11'd2040, 9'd510);
                1:       write_page_counts(11'd0, 9'd0);
                2:       write_page_counts(11'd8, 9'd510);
                3:       write_page_counts(11'd2040, 9'd2);
                default: write_page_counts(CHR_W'($urandom_range(8, 2040)),
                                           PRG_W'($urandom_range(2, 510)));
            endcase
            run_random(PHASE_RANDOM);
            wait_quiet(1'b1);
        end

        $display("covered %0d CPU writes and %0d bank results over %0d page-count settings",
                 writes_done, results_seen, settings_done + 1);
        $display("%0d field mismatches, %0d results still outstanding",
                 mismatches, page_expect_q.size());
        if (mismatches == 0 && page_expect_q.size() == 0) begin
            $display("multicart_mmc3_bank_mapper_tb passed");
        end else begin
            $display("multicart_mmc3_bank_mapper_tb failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/mcmm_pkg.sv
hw/rtl/mcmm_in_if.sv
hw/rtl/mcmm_out_if.sv
hw/rtl/multicart_mmc3_bank_mapper.sv
test/multicart_mmc3_bank_mapper_tb.sv
